/* rtl/nac_pkg.sv */
// Shared types, codes and constants of the NRMSE accuracy checker.
package nac_pkg;

  // Sample and field widths
  localparam int SAMPLE_W    = 16;
  localparam int THRESH_W    = 32;
  localparam int FLOOR_W     = 16;
  localparam int SUM_W       = 64;
  localparam int PAIR_CNT_W  = 25;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  // Stream payload layout
  localparam int IN_DATA_W   = 2 * SAMPLE_W;
  localparam int OUT_BITS    = 2 + SUM_W + FLOOR_W + PAIR_CNT_W;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Multiplier sequence geometry: p = threshold * den is split in two halves
  localparam int PROD_P_W    = THRESH_W + FLOOR_W;
  localparam int P_HALF      = PROD_P_W / 2;
  localparam int SQ_W        = 2 * PROD_P_W;
  localparam int MUL_A_W     = 32;
  localparam int LIMB_W      = 32;
  localparam int SUM_SHIFT   = 32;

  // Defaults
  localparam int COUNT_BITS_DEFAULT = 24;
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(655);
  localparam logic [FLOOR_W-1:0]  FLOOR_RESET  = FLOOR_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FLOOR = CFG_IDX_W'(1);

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_MUL_P,
    ST_SQ_LL,
    ST_SQ_LH,
    ST_SQ_HH,
    ST_RHS_0,
    ST_RHS_1,
    ST_RHS_2,
    ST_EMIT
  } nac_state_t;

  // Operations of the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P,
    MUL_LL,
    MUL_LH,
    MUL_HH,
    MUL_R0,
    MUL_R1,
    MUL_R2
  } mul_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    take;
    logic    load_den;
    mul_op_t op;
    logic    emit;
  } nac_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } nac_stat_t;

endpackage

/* rtl/nac_ctrl.sv */
// Controller state machine: intake, verdict multiply sequence and emit.
module nac_ctrl
  import nac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  input  nac_stat_t stat,
  output nac_cmd_t  cmd
);

  nac_state_t state;
  nac_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.take     = 1'b0;
    cmd.load_den = 1'b0;
    cmd.op       = MUL_NONE;
    cmd.emit     = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid && in_last) begin
          state_next = ST_DEN;
        end
      end
      ST_DEN: begin
        cmd.load_den = 1'b1;
        state_next   = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.op     = MUL_P;
        state_next = ST_SQ_LL;
      end
      ST_SQ_LL: begin
        cmd.op     = MUL_LL;
        state_next = ST_SQ_LH;
      end
      ST_SQ_LH: begin
        cmd.op     = MUL_LH;
        state_next = ST_SQ_HH;
      end
      ST_SQ_HH: begin
        cmd.op     = MUL_HH;
        state_next = ST_RHS_0;
      end
      ST_RHS_0: begin
        cmd.op     = MUL_R0;
        state_next = ST_RHS_1;
      end
      ST_RHS_1: begin
        cmd.op     = MUL_R1;
        state_next = ST_RHS_2;
      end
      ST_RHS_2: begin
        cmd.op     = MUL_R2;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/nac_datapath.sv */
// Datapath: accumulators, extremes, shared multiplier and result register.
module nac_datapath
  import nac_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nac_cmd_t               cmd,
  output nac_stat_t              stat,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic [IN_DATA_W-1:0]   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_DATA_W-1:0]  out_data
);

  localparam int CNT_W  = COUNT_BITS + 1;
  localparam int MB_W   = (CNT_W > MUL_A_W) ? CNT_W : MUL_A_W;
  localparam int PROD_W = MUL_A_W + MB_W;
  localparam int RHS_W  = SQ_W + MB_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << COUNT_BITS;

  // Configuration registers
  logic [THRESH_W-1:0] threshold;
  logic [FLOOR_W-1:0]  range_floor;

  // Tensor state
  logic [SUM_W-1:0]           sum_sq;
  logic [CNT_W-1:0]           count;
  logic signed [SAMPLE_W-1:0] act_high;
  logic signed [SAMPLE_W-1:0] act_low;
  logic signed [SAMPLE_W-1:0] ref_high;
  logic signed [SAMPLE_W-1:0] ref_low;

  // Intake stage
  logic                  mag_valid;
  logic [SAMPLE_W-1:0]   mag;
  logic                  accept;
  logic signed [SAMPLE_W-1:0] a_s;
  logic signed [SAMPLE_W-1:0] r_s;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          diff_abs;

  // Verdict datapath
  logic [FLOOR_W-1:0]   den;
  logic [FLOOR_W-1:0]   ra;
  logic [FLOOR_W-1:0]   rr;
  logic [FLOOR_W-1:0]   den_next;
  logic [PROD_P_W-1:0]  p;
  logic [SQ_W-1:0]      sqr;
  logic [RHS_W-1:0]     rhs;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [PROD_W-1:0]    prod;
  logic [SAMPLE_W*2-1:0] sq_item;
  logic [SUM_W:0]       sum_ext;
  logic [RHS_W-1:0]     lhs;
  logic                 exact;
  logic                 ok;
  logic [CNT_W+PAIR_CNT_W-1:0] count_ext;

  assign accept        = in_valid && cmd.take;
  assign stat.out_free = !out_valid || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESH_RESET;
      range_floor <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:   threshold   <= cfg_data[THRESH_W-1:0];
        CFG_RANGE_FLOOR: range_floor <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Difference magnitude of the incoming pair
  always_comb begin
    a_s      = in_data[SAMPLE_W-1:0];
    r_s      = in_data[IN_DATA_W-1:SAMPLE_W];
    diff     = {a_s[SAMPLE_W-1], a_s} - {r_s[SAMPLE_W-1], r_s};
    diff_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
  end

  // Register the magnitude before squaring
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else begin
      mag_valid <= accept;
    end
    if (accept) begin
      mag <= diff_abs[SAMPLE_W-1:0];
    end
  end

  // Square and saturating accumulate
  always_comb begin
    sq_item = (SAMPLE_W*2)'(mag) * (SAMPLE_W*2)'(mag);
    sum_ext = {1'b0, sum_sq} + (SUM_W+1)'(sq_item);
  end

  // Tensor state: count, extremes, sum; clear on emit
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      sum_sq   <= '0;
      count    <= '0;
      act_high <= '0;
      act_low  <= '0;
      ref_high <= '0;
      ref_low  <= '0;
    end else begin
      if (mag_valid) begin
        sum_sq <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      end
      if (accept) begin
        if (count != CNT_MAX) begin
          count <= count + CNT_W'(1);
        end
        if (a_s > act_high) act_high <= a_s;
        if (a_s < act_low)  act_low  <= a_s;
        if (r_s > ref_high) ref_high <= r_s;
        if (r_s < ref_low)  ref_low  <= r_s;
      end
    end
  end

  // Denominator: largest of floor and the two zero-anchored ranges
  always_comb begin
    ra       = FLOOR_W'(act_high) - FLOOR_W'(act_low);
    rr       = FLOOR_W'(ref_high) - FLOOR_W'(ref_low);
    den_next = range_floor;
    if (ra > den_next) den_next = ra;
    if (rr > den_next) den_next = rr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_den) begin
      den <= den_next;
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      MUL_P: begin
        mul_a = threshold;
        mul_b = MB_W'(den);
      end
      MUL_LL: begin
        mul_a = MUL_A_W'(p[P_HALF-1:0]);
        mul_b = MB_W'(p[P_HALF-1:0]);
      end
      MUL_LH: begin
        mul_a = MUL_A_W'(p[P_HALF-1:0]);
        mul_b = MB_W'(p[PROD_P_W-1:P_HALF]);
      end
      MUL_HH: begin
        mul_a = MUL_A_W'(p[PROD_P_W-1:P_HALF]);
        mul_b = MB_W'(p[PROD_P_W-1:P_HALF]);
      end
      MUL_R0: begin
        mul_a = sqr[LIMB_W-1:0];
        mul_b = MB_W'(count);
      end
      MUL_R1: begin
        mul_a = sqr[2*LIMB_W-1:LIMB_W];
        mul_b = MB_W'(count);
      end
      MUL_R2: begin
        mul_a = sqr[3*LIMB_W-1:2*LIMB_W];
        mul_b = MB_W'(count);
      end
      default: ;
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Accumulate partial products: p^2 into sqr, count * p^2 into rhs
  always_ff @(posedge clk) begin
    case (cmd.op)
      MUL_P:  p   <= prod[PROD_P_W-1:0];
      MUL_LL: sqr <= SQ_W'(prod);
      MUL_LH: sqr <= sqr + (SQ_W'(prod) << (P_HALF + 1));
      MUL_HH: sqr <= sqr + (SQ_W'(prod) << (2 * P_HALF));
      MUL_R0: rhs <= RHS_W'(prod);
      MUL_R1: rhs <= rhs + (RHS_W'(prod) << LIMB_W);
      MUL_R2: rhs <= rhs + (RHS_W'(prod) << (2 * LIMB_W));
      default: ;
    endcase
  end

  // Verdict: sum * 2^32 <= count * (threshold * den)^2
  always_comb begin
    lhs       = RHS_W'(sum_sq) << SUM_SHIFT;
    exact     = (sum_sq == '0);
    ok        = exact || (lhs <= rhs);
    count_ext = (CNT_W+PAIR_CNT_W)'(count);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_data <= OUT_DATA_W'({count_ext[PAIR_CNT_W-1:0], den, sum_sq, exact, ok});
    end
  end

endmodule

/* rtl/nrmse_accuracy_check_core.sv */
// Top level of the NRMSE accuracy checker: controller plus datapath.
//
//  channel  direction  handshake                     payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   tdata: actual, reference; tlast
//  m_axis   out        m_axis_tvalid/m_axis_tready   tdata: verdict fields
//  cfg      in         cfg_we (no wait)              cfg_index, cfg_data
//
// Pairs are taken one per clock while the tensor streams in; only the
// squaring of a pair runs in the cycle after its transfer.
// After the last pair the verdict is worked out by the shared 32-bit
// multiplier, walking p = threshold*den, p^2 and count*p^2 in pieces.
// A finished verdict waits in the output register; the next tensor streams
// in meanwhile, and only its own verdict waits for that register to drain.
// Reset is synchronous and clears control, tensor and valid state; no clearing pass.
module nrmse_accuracy_check_core
  import nac_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] actual_sample, [31:16] reference_sample
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] pass, [1] exact_match, [65:2] error_sum, [81:66] range_used,
  // [106:82] pair_count, [111:107] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  nac_cmd_t  cmd;
  nac_stat_t stat;

  assign s_axis_tready = cmd.take;

  // Sequencer
  nac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Arithmetic and storage
  nac_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

/* rtl/nac_checker.sv */
// Port-level checks of the NRMSE accuracy checker, bound to the top level.
module nac_checker
  import nac_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  s_axis_tlast,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // An exact match always passes
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
    else $error("exact match without pass");

  // Exact match flags a zero error sum and nothing else
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1] == (m_axis_tdata[65:2] == '0)))
    else $error("exact match disagrees with error sum");

  // A verdict always counts the last pair
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[106:82] != '0))
    else $error("verdict with zero pair count");

  // Intake stops right after the last pair's transfer
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken during verdict");

endmodule

bind nrmse_accuracy_check_core nac_checker u_nac_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
